FILE: rtl/trte_pkg.sv
// Package for the trace record timestamp encoder.
// Types, field widths, register codes and constants shared by all rtl files.
// No dependencies.
package trte_pkg;

  localparam int unsigned KIND_W   = 5;
  localparam int unsigned ID_W     = 20;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned DELTA_W  = 31;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // stream payload widths
  localparam int unsigned S_TDATA_W = 216;  // 212 bits of fields, padded to bytes
  localparam int unsigned M_TDATA_W = 128;

  localparam logic [WORD_W-1:0]  DELTA_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  localparam logic [SHIFT_W-1:0] TIME_SHIFT_RESET     = 6'd4;
  localparam logic [COUNT_W-1:0] EPOCH_INTERVAL_RESET = 16'd1024;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_SHIFT     = 8'd0,
    CFG_EPOCH_INTERVAL = 8'd1
  } cfg_index_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [WORD_W-1:0] bytes;
    logic [WORD_W-1:0] extra;
    logic [WORD_W-1:0] now;
  } event_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_lo;
    logic [WORD_W-1:0] word_hi;
    logic              last;
  } record_t;

  // status from the record builder to the control
  typedef struct packed {
    logic              need_epoch;
    logic [WORD_W-1:0] anchor_time;
  } pack_ctl_t;

endpackage

FILE: rtl/trte_size_class.sv
// Size class of a payload length: ceil(log2(len)), 0 for 0, 1 for 1 and 2.
// Uses trte_pkg.
module trte_size_class (
  input  logic [trte_pkg::WORD_W-1:0]  len,
  output logic [trte_pkg::CLASS_W-1:0] len_class
);
  import trte_pkg::*;

  logic [WORD_W-1:0] len_m1;
  logic [6:0]        msb_idx;

  assign len_m1 = len - WORD_W'(1);

  // leading-one position of len-1
  always_comb begin
    msb_idx = 7'd0;
    for (int i = 0; i < WORD_W; i++) begin
      if (len_m1[i]) msb_idx = 7'(i);
    end
  end

  always_comb begin
    priority if (len == '0) begin
      len_class = '0;
    end else if (len == WORD_W'(1)) begin
      len_class = CLASS_W'(1);
    end else begin
      len_class = CLASS_W'(msb_idx) + CLASS_W'(1);
    end
  end

endmodule

FILE: rtl/trte_record_pack.sv
// Record builder: delta timestamp, epoch decision and record packing.
// Uses trte_pkg and trte_size_class.
module trte_record_pack (
  input  trte_pkg::event_t                 ev,
  input  logic                             epoch_done,
  input  logic [trte_pkg::WORD_W-1:0]      epoch_time,
  input  logic [trte_pkg::COUNT_W-1:0]     count,
  input  logic [trte_pkg::SHIFT_W-1:0]     time_shift,
  input  logic [trte_pkg::COUNT_W-1:0]     epoch_interval,
  output trte_pkg::pack_ctl_t              ctl,
  output trte_pkg::record_t                epoch_rec,
  output trte_pkg::record_t                event_rec
);
  import trte_pkg::*;

  logic [WORD_W-1:0]  delta;
  logic [DELTA_W-1:0] delta_field;
  logic [CLASS_W-1:0] len_class;

  trte_size_class u_class (
    .len       (ev.bytes),
    .len_class (len_class)
  );

  assign delta = (ev.now - epoch_time) >> time_shift;

  // once the anchor for this event went out, the event carries delta 0
  assign ctl.need_epoch  = !epoch_done &&
                           ((epoch_time == '0) || (delta > DELTA_LIMIT) ||
                            (count >= epoch_interval));
  assign ctl.anchor_time = ev.now;

  assign delta_field = epoch_done ? '0 : delta[DELTA_W-1:0];

  assign epoch_rec.word_lo = '0;
  assign epoch_rec.word_hi = ev.now;
  assign epoch_rec.last    = 1'b0;

  assign event_rec.word_lo = {delta_field, len_class, ev.kind, ev.id};
  assign event_rec.word_hi = ev.extra;
  assign event_rec.last    = 1'b1;

endmodule

FILE: rtl/trace_record_timestamp_encoder.sv
// Trace record timestamp encoder: one input register, one result register.
// An event record passes through the input register and then the result register,
// after the epoch record when one goes out first. Throughput: one event per cycle
// while the output is not stalled; an event that emits an epoch record takes a
// second pass (the held event goes into the result register again). Reset (rst,
// synchronous, active high) empties both registers, clears the epoch and record
// count and loads time_shift = 4, epoch_interval = 1024.
module trace_record_timestamp_encoder (
  input  logic                                 clk,
  input  logic                                 rst,
  // input events
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // fields from bit 0: event_id[19:0], payload_len[83:20],
  // extra_word[147:84], now_time[211:148], zero pad[215:212]
  input  logic [trte_pkg::S_TDATA_W-1:0]       s_tdata,
  // fields from bit 0: event_kind[4:0]
  input  logic [trte_pkg::KIND_W-1:0]          s_tuser,
  // output records
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // fields from bit 0: word_lo[63:0], word_hi[127:64]
  output logic [trte_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                 m_tlast,   // last_record
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [trte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [trte_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import trte_pkg::*;

  // input register
  logic   a_valid;
  event_t a_ev;
  logic   epoch_done;   // epoch record for the held event already sent

  // block state
  logic [WORD_W-1:0]  epoch_time;
  logic [COUNT_W-1:0] records_since_epoch;
  logic [SHIFT_W-1:0] time_shift;
  logic [COUNT_W-1:0] epoch_interval;

  // result register
  logic    out_valid;
  record_t out_rec;

  pack_ctl_t ctl;
  record_t   epoch_rec;
  record_t   event_rec;

  logic out_can_load;
  logic fire;
  logic a_consume;
  logic s_accept;
  logic cfg_accept;

  trte_record_pack u_pack (
    .ev             (a_ev),
    .epoch_done     (epoch_done),
    .epoch_time     (epoch_time),
    .count          (records_since_epoch),
    .time_shift     (time_shift),
    .epoch_interval (epoch_interval),
    .ctl            (ctl),
    .epoch_rec      (epoch_rec),
    .event_rec      (event_rec)
  );

  // A result moves into the result register whenever it is empty or draining.
  // An epoch transaction keeps the event in the input register for one more pass.
  assign out_can_load = !out_valid || m_tready;
  assign fire         = a_valid && out_can_load;
  assign a_consume    = fire && !ctl.need_epoch;
  assign s_tready     = !a_valid || a_consume;
  assign s_accept     = s_tvalid && s_tready;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid             <= 1'b0;
      epoch_done          <= 1'b0;
      out_valid           <= 1'b0;
      epoch_time          <= '0;
      records_since_epoch <= '0;
      time_shift          <= TIME_SHIFT_RESET;
      epoch_interval      <= EPOCH_INTERVAL_RESET;
    end else begin
      if (cfg_accept) begin
        unique case (cfg_index)
          CFG_TIME_SHIFT:     time_shift     <= cfg_data[SHIFT_W-1:0];
          CFG_EPOCH_INTERVAL: epoch_interval <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (s_accept) begin
        a_valid    <= 1'b1;
        epoch_done <= 1'b0;
      end else if (a_consume) begin
        a_valid <= 1'b0;
      end else if (fire) begin
        epoch_done <= 1'b1;  // epoch sent, event follows next pass
      end

      if (fire) begin
        if (ctl.need_epoch) begin
          epoch_time          <= ctl.anchor_time;
          records_since_epoch <= '0;
        end else if (records_since_epoch != COUNT_MAX) begin
          records_since_epoch <= records_since_epoch + COUNT_W'(1);
        end
      end

      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      a_ev.kind  <= s_tuser;
      a_ev.id    <= s_tdata[19:0];
      a_ev.bytes <= s_tdata[83:20];
      a_ev.extra <= s_tdata[147:84];
      a_ev.now   <= s_tdata[211:148];
    end
    if (fire) begin
      out_rec <= ctl.need_epoch ? epoch_rec : event_rec;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_rec.word_hi, out_rec.word_lo};
  assign m_tlast  = out_rec.last;

endmodule

FILE: rtl/trte_checker.sv
// Port-level checker for the trace record timestamp encoder, with its bind.
// Uses trte_pkg; binds to trace_record_timestamp_encoder.
module trte_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [trte_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import trte_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // epoch record has a zero first word
  a_epoch_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[63:0] == '0)
    else $error("epoch record with nonzero word_lo");

  // event behind a stalled epoch record blocks new input
  a_epoch_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast && !m_tready |-> !s_tready)
    else $error("input taken while epoch record stalled");

  // event record right after its epoch, with delta zero
  a_epoch_follow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tdata[63:33] == '0)
    else $error("event record missing after epoch record");

endmodule

bind trace_record_timestamp_encoder trte_checker u_trte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: bench/trace_record_timestamp_encoder_test.sv
// Self-checking bench for the trace record timestamp encoder.
// Drives event and register transactions and scores every output record.
// Depends on trte_pkg and trace_record_timestamp_encoder from rtl.
`timescale 1ns / 100ps

module trace_record_timestamp_encoder_test;
  import trte_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int unsigned CHOKE_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES  = 4;     // quiet cycles before a register write
  localparam int unsigned DRAIN_CYCLES   = 12;    // tail after the last record
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_EVENTS   = 56;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;  // no register behind it

  // expectation pinned by a directed row instead of the predictor
  typedef struct packed {
    logic              valid;
    logic              epoch;    // an anchor record comes first
    logic [WORD_W-1:0] lo;       // word_lo of the event record
  } pin_t;

  // one directed row: either a register write or an event
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    event_t                ev;
    pin_t                  pin;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  trace_record_timestamp_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Encoder model: own copy of the anchor state and both registers
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]  anchor_time  = '0;
  logic [COUNT_W-1:0] since_anchor = '0;
  logic [SHIFT_W-1:0] shift_reg    = TIME_SHIFT_RESET;
  logic [COUNT_W-1:0] interval_reg = EPOCH_INTERVAL_RESET;

  record_t pending_records[$];   // records the block still owes, oldest first
  pin_t    cur_pin = '0;          // travels alongside the offered event

  int unsigned mismatches   = 0;
  int unsigned events_in    = 0;
  int unsigned records_out  = 0;
  int unsigned anchors_out  = 0;
  int unsigned writes_done  = 0;
  int unsigned idle_run     = 0;
  bit          choke_req    = 1'b0;
  bit          choke_taken  = 1'b0;

  // ceil(log2(len)), with 0 -> 0 and 1,2 -> 1; tops out at 64
  function automatic logic [CLASS_W-1:0] len_class(input logic [WORD_W-1:0] len);
    int c;
    if (len == '0) return '0;
    c = 1;
    while (c < 64 && ((64'd1 << c) < len)) c++;
    return CLASS_W'(c);
  endfunction

  // Advances the anchor state by one event; rec_a is always the first record out.
  task automatic encode_event(input event_t ev, output int n,
                              output record_t rec_a, output record_t rec_b);
    logic [WORD_W-1:0] delta;
    record_t           ev_rec;
    delta = (ev.now - anchor_time) >> shift_reg;
    n     = 0;
    rec_a = '0;
    rec_b = '0;
    // re-anchor: no epoch yet, delta too wide (incl. wrapped time), or count reached
    if (anchor_time == '0 || delta > DELTA_LIMIT || since_anchor >= interval_reg) begin
      anchor_time   = ev.now;
      since_anchor  = '0;
      delta         = '0;
      rec_a.word_lo = '0;
      rec_a.word_hi = ev.now;
      rec_a.last    = 1'b0;
      n             = 1;
    end
    if (since_anchor != COUNT_MAX) since_anchor++;
    ev_rec.word_lo = WORD_W'(ev.id) | (WORD_W'(ev.kind) << 20) |
                     (WORD_W'(len_class(ev.bytes)) << 25) |
                     ((delta & DELTA_LIMIT) << 33);
    ev_rec.word_hi = ev.extra;
    ev_rec.last    = 1'b1;
    if (n == 0) rec_a = ev_rec;
    else rec_b = ev_rec;
    n++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: scores output records, predicts on input, tracks register writes.
  // Everything is sampled at the rising edge, before the block updates.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bit          any_xfer;
    int          n;
    record_t     ra, rb, exp_rec;
    event_t      ev;
    if (rst) begin
      idle_run     = 0;
      anchor_time  = '0;
      since_anchor = '0;
      shift_reg    = TIME_SHIFT_RESET;
      interval_reg = EPOCH_INTERVAL_RESET;
    end else begin
      any_xfer = 1'b0;

      if (m_tvalid && m_tready) begin
        any_xfer = 1'b1;
        records_out++;
        if (!m_tlast) anchors_out++;
        if (pending_records.size() == 0) begin
          mismatches++;
          $display("%0t: record with nothing pending: lo %h hi %h last %b",
                   $time, m_tdata[63:0], m_tdata[127:64], m_tlast);
        end else begin
          exp_rec = pending_records.pop_front();
          if (m_tdata[63:0] !== exp_rec.word_lo) begin
            mismatches++;
            $display("%0t: word_lo expected %h got %h", $time, exp_rec.word_lo, m_tdata[63:0]);
          end
          if (m_tdata[127:64] !== exp_rec.word_hi) begin
            mismatches++;
            $display("%0t: word_hi expected %h got %h", $time, exp_rec.word_hi,
                     m_tdata[127:64]);
          end
          if (m_tlast !== exp_rec.last) begin
            mismatches++;
            $display("%0t: last_record expected %b got %b", $time, exp_rec.last, m_tlast);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        any_xfer = 1'b1;
        events_in++;
        ev.kind  = s_tuser;
        ev.id    = s_tdata[19:0];
        ev.bytes = s_tdata[83:20];
        ev.extra = s_tdata[147:84];
        ev.now   = s_tdata[211:148];
        encode_event(ev, n, ra, rb);
        if (cur_pin.valid) begin
          // directed row with hand-written expectation; model state still advances
          if (cur_pin.epoch) pending_records.push_back('{word_lo: '0, word_hi: ev.now,
                                                         last: 1'b0});
          pending_records.push_back('{word_lo: cur_pin.lo, word_hi: ev.extra, last: 1'b1});
        end else begin
          pending_records.push_back(ra);
          if (n == 2) pending_records.push_back(rb);
        end
      end

      if (cfg_valid && cfg_ready) begin
        any_xfer = 1'b1;
        writes_done++;
        case (cfg_index)
          CFG_TIME_SHIFT:     shift_reg    = cfg_data[SHIFT_W-1:0];
          CFG_EPOCH_INTERVAL: interval_reg = cfg_data;
          default: ;
        endcase
      end

      idle_run = any_xfer ? 0 : idle_run + 1;
    end
  end

  // watchdog: nothing moved on any channel for too long
  initial begin
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("%0t: watchdog expired, %0d records still pending", $time,
             pending_records.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random ready pattern, stretches of full rate, one long choke
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int burst, gap;
    while (rst) @(posedge clk);
    forever begin
      if (choke_req && !choke_taken) begin
        // hold off while the sender keeps offering, so the block backs up
        choke_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 16);
        m_tready <= 1'b1;
        repeat (burst) @(posedge clk);
        gap = idle_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side tasks
  // ---------------------------------------------------------------------------
  // Offer one event and hold it until accepted; steady skips the idle gap after it.
  task automatic send_event(input event_t ev, input pin_t pin, input bit steady);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ev.now, ev.extra, ev.bytes, ev.id};
    s_tuser  <= ev.kind;
    cur_pin  <= pin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every event yields a record, so an empty queue means the block is idle.
  // It first waits on the clock, so the monitor has queued the last accepted event.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------------
  row_t directed_rows[$];

  function automatic void add_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                    input logic [WORD_W-1:0] bytes,
                                    input logic [WORD_W-1:0] extra,
                                    input logic [WORD_W-1:0] now);
    row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = '0;
    row.reg_val  = '0;
    row.ev       = '{kind: kind, id: id, bytes: bytes, extra: extra, now: now};
    row.pin      = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_pinned(input logic [KIND_W-1:0] kind,
                                     input logic [ID_W-1:0] id,
                                     input logic [WORD_W-1:0] bytes,
                                     input logic [WORD_W-1:0] extra,
                                     input logic [WORD_W-1:0] now,
                                     input logic epoch, input logic [WORD_W-1:0] lo);
    add_event(kind, id, bytes, extra, now);
    directed_rows[$].pin = '{valid: 1'b1, epoch: epoch, lo: lo};
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    logic [WORD_W-1:0] ones;
    ones = '1;
    // reset settings: shift 4, interval 1024, no epoch yet -> anchor first
    add_pinned(5'd0, 20'h0, 64'd0, 64'd0, 64'd1000, 1'b1, 64'd0);
    // widest kind/id, 80 ns later -> delta 5, length 1 -> class 1
    add_pinned(5'd31, 20'hFFFFF, 64'd1, ones, 64'd1080, 1'b0,
               64'hFFFFF | (64'd31 << 20) | (64'd1 << 25) | (64'd5 << 33));
    // length 2 -> class 1, same time as anchor -> delta 0
    add_pinned(5'd1, 20'h1, 64'd2, 64'h0123_4567_89AB_CDEF, 64'd1000, 1'b0,
               64'd1 | (64'd1 << 20) | (64'd1 << 25));
    add_event(5'd2, 20'h2, 64'd3, 64'hA5A5_A5A5_5A5A_5A5A, 64'd1016);
    add_event(5'd16, 20'h80000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'd2000);
    add_event(5'd8, 20'h55555, 64'h8000_0000_0000_0001, 64'h1, 64'd3000);
    // largest length -> class 64
    add_pinned(5'd5, 20'h12345, ones, 64'hFFFF_0000_FFFF_0000, 64'd1000, 1'b0,
               64'h12345 | (64'd5 << 20) | (64'd64 << 25));
    // widest delta that still fits, then one step past it forces an anchor
    add_event(5'd9, 20'hAAAAA, 64'd1024, 64'h0F0F_0F0F_0F0F_0F0F,
              64'd1000 + (64'h7FFF_FFFF << 4));
    add_pinned(5'd3, 20'h7, 64'd0, 64'h0000_0000_0000_00FF,
               64'd1000 + (64'h8000_0000 << 4), 1'b1, 64'd7 | (64'd3 << 20));
    // time going backwards wraps and forces an anchor
    add_pinned(5'd0, 20'h0, 64'd0, 64'hDEAD_BEEF_0000_0001, 64'd500, 1'b1, 64'd0);
    // anchor at time zero, so the next event again has no epoch
    add_event(5'd10, 20'h3C3C3, 64'd5, 64'h2, 64'd0);
    add_event(5'd11, 20'hC3C3C, 64'd6, 64'h3, 64'd100);
    // maximum time, then zero: the difference wraps to 1
    add_event(5'd12, 20'hFFFF0, 64'd7, 64'h4, ones);
    add_event(5'd13, 20'h0000F, 64'd8, 64'h5, 64'd0);
    // no shift, interval 1: every second record count re-anchors
    add_write(CFG_TIME_SHIFT, 16'd0);
    add_write(CFG_EPOCH_INTERVAL, 16'd1);
    add_event(5'd14, 20'h11111, 64'd9, 64'h6, 64'd50);
    add_event(5'd15, 20'h22222, 64'd10, 64'h7, 64'd60);
    // widest shift (upper data bits set), interval zero: anchor on every event
    add_write(CFG_TIME_SHIFT, 16'hFFFF);
    add_write(CFG_EPOCH_INTERVAL, 16'd0);
    add_event(5'd17, 20'h33333, 64'd11, 64'h8, 64'd70);
    add_event(5'd18, 20'h44444, 64'd12, 64'h9, ones - 64'd1);
    // unused index must leave both registers alone
    add_write(CFG_UNUSED, 16'hFFFF);
    add_write(CFG_TIME_SHIFT, 16'd8);
    add_write(CFG_EPOCH_INTERVAL, 16'hFFFF);
    add_event(5'd19, 20'h66666, 64'd100, 64'hA, 64'd10_000);
    add_event(5'd20, 20'h77777, 64'd200, 64'hB, 64'd10_256);
    add_event(5'd21, 20'h88888, 64'd300, 64'hC, 64'd10_512);
    add_event(5'd22, 20'h99999, 64'd400, 64'hD, 64'd10_768);
    // interval dropped below the running count re-anchors on the next event
    add_write(CFG_EPOCH_INTERVAL, 16'd2);
    add_event(5'd23, 20'hBBBBB, 64'd500, 64'hE, 64'd11_024);
    add_event(5'd24, 20'hCCCCC, 64'd600, 64'hF, 64'd11_280);
    add_event(5'd25, 20'hDDDDD, 64'd700, 64'h10, 64'd11_536);
  endfunction

  // ---------------------------------------------------------------------------
  // Random event generation
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] sim_clock_ns = 64'd5000;

  // Time mostly creeps forward; sometimes jumps, runs back, or hits the extremes.
  function automatic logic [WORD_W-1:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)      sim_clock_ns += WORD_W'($urandom_range(0, 4000));
    else if (r < 88) sim_clock_ns += {$urandom, $urandom} >> $urandom_range(20, 40);
    else if (r < 93) sim_clock_ns -= WORD_W'($urandom_range(1, 1000));
    else if (r < 96) sim_clock_ns = {$urandom, $urandom};
    else if (r < 98) sim_clock_ns = '0;
    else             sim_clock_ns = '1;
    return sim_clock_ns;
  endfunction

  function automatic logic [WORD_W-1:0] random_length();
    int          r;
    logic [WORD_W-1:0] p;
    r = $urandom_range(0, 99);
    if (r < 30) return WORD_W'($urandom_range(0, 70));
    if (r < 55) begin
      // around a power of two, where the size class steps
      p = 64'd1 << $urandom_range(0, 63);
      return p + WORD_W'($urandom_range(0, 2)) - 64'd1;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic event_t random_event();
    event_t ev;
    ev.kind  = KIND_W'($urandom);
    ev.id    = ID_W'($urandom);
    ev.bytes = random_length();
    ev.extra = {$urandom, $urandom};
    ev.now   = next_time();
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [SHIFT_W-1:0]  shift_val;
    logic [COUNT_W-1:0]  interval_val;
    bit                  steady;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_directed();
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_event(directed_rows[i].ev, directed_rows[i].pin, 1'b0);
      end
    end

    // random phases, each under its own register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin shift_val = 6'd4;  interval_val = 16'd1024; end
        1: begin shift_val = 6'd0;  interval_val = 16'd1; end
        2: begin shift_val = 6'd63; interval_val = 16'hFFFF; end
        3: begin shift_val = 6'd0;  interval_val = 16'hFFFF; end
        4: begin shift_val = SHIFT_W'($urandom); interval_val = 16'($urandom_range(1, 8)); end
        5: begin shift_val = SHIFT_W'($urandom); interval_val = 16'($urandom_range(1, 64)); end
        6: begin shift_val = 6'd31; interval_val = 16'd3; end
        default: begin
          shift_val    = SHIFT_W'($urandom);
          interval_val = 16'($urandom_range(1, 65535));
        end
      endcase
      settle();
      // junk in the upper data bits of the shift write must be ignored
      write_reg(CFG_TIME_SHIFT, (16'($urandom) & 16'hFFC0) | 16'(shift_val));
      write_reg(CFG_EPOCH_INTERVAL, interval_val);
      if (ph == 2) choke_req = 1'b1;   // receiver backs off while we keep sending
      steady = (ph == 3 || ph == 6);   // back-to-back offers in these phases
      for (int i = 0; i < PHASE_EVENTS; i++)
        send_event(random_event(), '0, steady);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d events, %0d records (%0d epoch anchors), %0d register writes",
             events_in, records_out, anchors_out, writes_done);
    $display("Found %0d field mismatches or stray records", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
